// ===== hdl/dual_wheel_pid_speed_control_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel PID speed controller
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_DEFINES_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DWPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dwpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_pkg
// Shared widths, constants, register codes and pipeline control types.
// ----------------------------------------------------------------------------
package dwpid_pkg;

  localparam int WHEELS         = 2;
  localparam int COUNT_BITS_DEF = 16;

  localparam int RATE_W   = 16;
  localparam int GAIN_W   = 12;
  localparam int DUTY_W   = 16;
  localparam int SUM_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PWM_SCALE  = 400;
  localparam int SCALE_W    = $clog2(PWM_SCALE);
  localparam int FRAC_SHIFT = 16;
  localparam int LIM_W      = 41;
  localparam logic [LIM_W-1:0] CMD_LIMIT = {1'b1, {(LIM_W-1){1'b0}}};
  localparam int PROD_W     = LIM_W + SCALE_W;
  localparam int SCALED_W   = PROD_W - FRAC_SHIFT;

  // Four lane stages plus the merged output register.
  localparam int LANE_STAGES = 4;
  localparam int PIPE_DEPTH  = LANE_STAGES + 1;

  localparam logic [RATE_W-1:0] TARGET_RATE_RST = 16'd9078;
  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 12'd461;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 12'd205;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 12'd26;
  localparam logic [DUTY_W-1:0] PWM_MIN_RST     = 16'd800;
  localparam logic [DUTY_W-1:0] PWM_MAX_RST     = 16'd22000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_RATE = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_PWM_MIN     = 3'd4,
    CFG_PWM_MAX     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] load;
    logic [PIPE_DEPTH-1:0] valid;
  } pipe_ctl_t;

endpackage

// ===== hdl/dwpid_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid channel interfaces
// Valid/ready channels for encoder count words and duty words.
// ----------------------------------------------------------------------------
interface dwpid_in_if #(
  parameter int COUNT_BITS = dwpid_pkg::COUNT_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] right_count;
  logic [COUNT_BITS-1:0] left_count;

  modport source (output valid, output right_count, output left_count, input ready);
  modport sink   (input valid, input right_count, input left_count, output ready);
endinterface

interface dwpid_out_if ();
  logic                          valid;
  logic                          ready;
  logic [dwpid_pkg::DUTY_W-1:0]  right_duty;
  logic [dwpid_pkg::DUTY_W-1:0]  left_duty;

  modport source (output valid, output right_duty, output left_duty, input ready);
  modport sink   (input valid, input right_duty, input left_duty, output ready);
endinterface

// ===== hdl/dwpid_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_lane
// One wheel: tick delta, error, saturating integral and derivative in the
// first stage, gain products, PID sum, then scaling to a duty value.
// ----------------------------------------------------------------------------
module dwpid_lane #(
  parameter int COUNT_BITS = dwpid_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dwpid_pkg::pipe_ctl_t               ctl,
  input  logic [COUNT_BITS-1:0]              count,
  input  logic [dwpid_pkg::RATE_W-1:0]       target_rate,
  input  logic [dwpid_pkg::GAIN_W-1:0]       gain_p,
  input  logic [dwpid_pkg::GAIN_W-1:0]       gain_i,
  input  logic [dwpid_pkg::GAIN_W-1:0]       gain_d,
  output logic [dwpid_pkg::SCALED_W-1:0]     scaled
);

  localparam int EW   = COUNT_BITS + dwpid_pkg::FRAC_BITS + 1;
  localparam int DW   = EW + 1;
  localparam int SW   = dwpid_pkg::SUM_W;
  localparam int AW   = ((EW > SW) ? EW : SW) + 1;
  localparam int GW   = dwpid_pkg::GAIN_W + 1;
  localparam int PW_E = EW + GW;
  localparam int PW_S = SW + GW;
  localparam int PW_D = DW + GW;
  localparam int CW   = ((PW_D > PW_S) ? PW_D : PW_S) + 2;
  localparam int LW   = dwpid_pkg::LIM_W;

  // Loop state
  logic [COUNT_BITS-1:0]  last_count_r;
  logic signed [SW-1:0]   error_sum_r;
  logic signed [EW-1:0]   last_error_r;

  // Stage registers
  logic signed [EW-1:0]   e1_r;
  logic signed [SW-1:0]   s1_r;
  logic signed [DW-1:0]   d1_r;
  logic signed [PW_E-1:0] pe_r;
  logic signed [PW_S-1:0] pi_r;
  logic signed [PW_D-1:0] pd_r;
  logic signed [CW-1:0]   cmd_r;
  logic [dwpid_pkg::SCALED_W-1:0] scaled_r;

  logic [COUNT_BITS-1:0]  delta_c;
  logic signed [EW-1:0]   e_c;
  logic signed [AW-1:0]   sum_full_c;
  logic [SW-1:0]          sum_lo_c;
  logic signed [SW-1:0]   s_c;
  logic signed [DW-1:0]   d_c;
  logic signed [GW-1:0]   gp_c;
  logic signed [GW-1:0]   gi_c;
  logic signed [GW-1:0]   gd_c;
  logic                   cmd_pos_c;
  logic                   cmd_big_c;
  logic [LW-1:0]          cmd_lim_c;
  logic [dwpid_pkg::PROD_W-1:0] prod_c;

  // Stage 1: error, saturating integral and derivative; closes the per-sample loop.
  always_comb begin
    delta_c    = count - last_count_r;
    e_c        = $signed(EW'(target_rate)) -
                 $signed(EW'({delta_c, {dwpid_pkg::FRAC_BITS{1'b0}}}));
    sum_full_c = AW'(error_sum_r) + AW'(e_c);
    sum_lo_c   = sum_full_c[SW-1:0];
    if (sum_full_c == AW'($signed(sum_lo_c))) begin
      s_c = $signed(sum_lo_c);
    end else if (sum_full_c[AW-1]) begin
      s_c = $signed({1'b1, {(SW-1){1'b0}}});
    end else begin
      s_c = $signed({1'b0, {(SW-1){1'b1}}});
    end
    d_c = DW'(e_c) - DW'(last_error_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (ctl.load[0]) begin
      last_count_r <= count;
      error_sum_r  <= s_c;
      last_error_r <= e_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      e1_r <= e_c;
      s1_r <= s_c;
      d1_r <= d_c;
    end
  end

  // Stage 2: gain products.
  assign gp_c = $signed({1'b0, gain_p});
  assign gi_c = $signed({1'b0, gain_i});
  assign gd_c = $signed({1'b0, gain_d});

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      pe_r <= PW_E'(e1_r) * PW_E'(gp_c);
      pi_r <= PW_S'(s1_r) * PW_S'(gi_c);
      pd_r <= PW_D'(d1_r) * PW_D'(gd_c);
    end
  end

  // Stage 3: PID sum in Q.16.
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      cmd_r <= CW'(pe_r) + CW'(pi_r) + CW'(pd_r);
    end
  end

  // Stage 4: non-positive commands give zero, large ones are limited, then
  // the command is scaled to PWM compare units.
  always_comb begin
    cmd_pos_c = !cmd_r[CW-1] && (cmd_r != '0);
    cmd_big_c = cmd_r[CW-2:0] > (CW-1)'(dwpid_pkg::CMD_LIMIT);
    if (!cmd_pos_c) begin
      cmd_lim_c = '0;
    end else if (cmd_big_c) begin
      cmd_lim_c = dwpid_pkg::CMD_LIMIT;
    end else begin
      cmd_lim_c = cmd_r[LW-1:0];
    end
    prod_c = dwpid_pkg::PROD_W'(cmd_lim_c) *
             dwpid_pkg::PROD_W'(dwpid_pkg::PWM_SCALE);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      scaled_r <= prod_c[dwpid_pkg::PROD_W-1:dwpid_pkg::FRAC_SHIFT];
    end
  end

  assign scaled = scaled_r;

endmodule

// ===== hdl/dwpid_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_merge
// Pipeline valid tracking and flow control, plus the output stage that
// clamps every lane's duty and registers the merged result word.
// ----------------------------------------------------------------------------
module dwpid_merge (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  output logic                                                 in_ready,
  input  logic [dwpid_pkg::WHEELS-1:0][dwpid_pkg::SCALED_W-1:0] scaled,
  input  logic [dwpid_pkg::DUTY_W-1:0]                         pwm_min,
  input  logic [dwpid_pkg::DUTY_W-1:0]                         pwm_max,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output logic [dwpid_pkg::WHEELS-1:0][dwpid_pkg::DUTY_W-1:0]  duty,
  output dwpid_pkg::pipe_ctl_t                                 ctl
);

  localparam int S  = dwpid_pkg::PIPE_DEPTH;
  localparam int SW = dwpid_pkg::SCALED_W;

  logic [S-1:0] valid_r;
  logic [S-1:0] valid_nxt;
  logic [S-1:0] free_c;
  logic [S-1:0] load_c;
  logic [S-1:0] drain_c;
  logic [dwpid_pkg::WHEELS-1:0][dwpid_pkg::DUTY_W-1:0] duty_r;
  logic [dwpid_pkg::WHEELS-1:0][dwpid_pkg::DUTY_W-1:0] duty_nxt;

  // A stage takes a word when it is empty or its word moves on this cycle,
  // so bubbles close up even while the output is stalled.
  always_comb begin
    free_c[S-1]  = !valid_r[S-1] || out_ready;
    drain_c[S-1] = out_ready;
    for (int k = S - 2; k >= 0; k--) begin
      free_c[k] = !valid_r[k] || free_c[k+1];
    end
    load_c[0] = in_valid && free_c[0];
    for (int k = 1; k < S; k++) begin
      load_c[k] = valid_r[k-1] && free_c[k];
    end
    for (int k = 0; k < S - 1; k++) begin
      drain_c[k] = load_c[k+1];
    end
    valid_nxt = load_c | (valid_r & ~drain_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Low clamp first, then the high clamp.
  always_comb begin
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    for (int w = 0; w < dwpid_pkg::WHEELS; w++) begin
      lo = (scaled[w] < SW'(pwm_min)) ? SW'(pwm_min) : scaled[w];
      hi = (lo > SW'(pwm_max)) ? SW'(pwm_max) : lo;
      duty_nxt[w] = hi[dwpid_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_c[S-1]) begin
      duty_r <= duty_nxt;
    end
  end

  assign in_ready  = free_c[0];
  assign out_valid = valid_r[S-1];
  assign duty      = duty_r;
  assign ctl.load  = load_c;
  assign ctl.valid = valid_r;

endmodule

// ===== hdl/dual_wheel_pid_speed_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_control
// Two-wheel PID speed controller fed by free-running encoder counters.
// ----------------------------------------------------------------------------
// Each input word carries both wheels' encoder counter values for one sample
// period; each output word carries both motors' PWM compare values. The block
// accepts one word per clock cycle while the output is not stalled. Each word
// passes the error and integral update that closes the per-wheel loop, then
// the gain products, the PID sum and the scaling, and last the clamp in the
// output register. The two wheels run in parallel lanes. A stalled output
// holds its word while the pipeline keeps filling, and input ready drops only
// when all five stages hold words. The first sample after reset takes the
// whole counter value as its tick delta. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while no words
// are in flight, as the block itself does not enforce this.
module dual_wheel_pid_speed_control #(
  parameter int COUNT_BITS = dwpid_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dwpid_in_if.sink                            in_chan,
  dwpid_out_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [dwpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwpid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "dual_wheel_pid_speed_control_defines.svh"

  localparam int WHEELS = dwpid_pkg::WHEELS;

  logic [dwpid_pkg::RATE_W-1:0] target_rate_r;
  logic [dwpid_pkg::GAIN_W-1:0] gain_p_r;
  logic [dwpid_pkg::GAIN_W-1:0] gain_i_r;
  logic [dwpid_pkg::GAIN_W-1:0] gain_d_r;
  logic [dwpid_pkg::DUTY_W-1:0] pwm_min_r;
  logic [dwpid_pkg::DUTY_W-1:0] pwm_max_r;

  dwpid_pkg::pipe_ctl_t ctl;
  logic [WHEELS-1:0][COUNT_BITS-1:0]         counts;
  logic [WHEELS-1:0][dwpid_pkg::SCALED_W-1:0] scaled;
  logic [WHEELS-1:0][dwpid_pkg::DUTY_W-1:0]   duty;
  logic in_ready_w;
  logic out_valid_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_rate_r <= dwpid_pkg::TARGET_RATE_RST;
      gain_p_r      <= dwpid_pkg::GAIN_P_RST;
      gain_i_r      <= dwpid_pkg::GAIN_I_RST;
      gain_d_r      <= dwpid_pkg::GAIN_D_RST;
      pwm_min_r     <= dwpid_pkg::PWM_MIN_RST;
      pwm_max_r     <= dwpid_pkg::PWM_MAX_RST;
    end else if (cfg_we) begin
      unique case (dwpid_pkg::cfg_reg_t'(cfg_index))
        dwpid_pkg::CFG_TARGET_RATE: target_rate_r <= cfg_wdata[dwpid_pkg::RATE_W-1:0];
        dwpid_pkg::CFG_GAIN_P:      gain_p_r      <= cfg_wdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::CFG_GAIN_I:      gain_i_r      <= cfg_wdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::CFG_GAIN_D:      gain_d_r      <= cfg_wdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::CFG_PWM_MIN:     pwm_min_r     <= cfg_wdata[dwpid_pkg::DUTY_W-1:0];
        dwpid_pkg::CFG_PWM_MAX:     pwm_max_r     <= cfg_wdata[dwpid_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Lane 0 is the right wheel, lane 1 the left wheel.
  assign counts[0] = COUNT_BITS'(in_chan.right_count);
  assign counts[1] = COUNT_BITS'(in_chan.left_count);

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    dwpid_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .count       (counts[w]),
      .target_rate (target_rate_r),
      .gain_p      (gain_p_r),
      .gain_i      (gain_i_r),
      .gain_d      (gain_d_r),
      .scaled      (scaled[w])
    );
  end

  dwpid_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready_w),
    .scaled    (scaled),
    .pwm_min   (pwm_min_r),
    .pwm_max   (pwm_max_r),
    .out_valid (out_valid_w),
    .out_ready (out_chan.ready),
    .duty      (duty),
    .ctl       (ctl)
  );

  assign in_chan.ready       = in_ready_w;
  assign out_chan.valid      = out_valid_w;
  assign out_chan.right_duty = duty[0];
  assign out_chan.left_duty  = duty[1];

  // Input is refused only when every pipeline stage holds a word.
  `DWPID_ASSERT_NOW(a_full_when_blocked, !in_ready_w, &ctl.valid, "input stalled with a bubble in the pipeline")
  // An accepted word always occupies the first stage in the next cycle.
  `DWPID_ASSERT_NEXT(a_accept_fills, in_chan.valid && in_ready_w, ctl.valid[0], "accepted word lost at stage one")
  // A new result appears only when the last lane stage held a word.
  `DWPID_ASSERT_NOW(a_out_from_lane, $rose(out_valid_w), $past(ctl.valid[dwpid_pkg::LANE_STAGES-1]), "result without a word in the last lane stage")

endmodule
